@@ rtl/riscv_attribute_section_parser_core_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the RISC-V attributes section parser
// Shared by every module that carries concurrent checks.
// ---------------------------------------------------------------------------
`ifndef RISCV_ATTRIBUTE_SECTION_PARSER_CORE_DEFINES_SVH
`define RISCV_ATTRIBUTE_SECTION_PARSER_CORE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define RASP_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies the consequent in the next cycle.
`define RASP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rasp_pkg.sv @@
// ---------------------------------------------------------------------------
// rasp_pkg
// Types and constants of the RISC-V attributes section parser.
// ---------------------------------------------------------------------------
package rasp_pkg;

	localparam int SECTION_MAX_BYTES = 1024;
	localparam int CNT_W = $clog2(SECTION_MAX_BYTES + 1);

	localparam logic [63:0] TAG_STACK_ALIGN = 64'd4;
	localparam logic [63:0] TAG_ARCH        = 64'd5;
	localparam logic [63:0] TAG_UNALIGNED   = 64'd6;

	localparam logic [6:0]  ULEB_SHIFT_MAX  = 7'd64;
	localparam logic [31:0] DATA_LEN_HDR    = 32'd5;

	typedef enum logic [1:0] {
		KIND_INT = 2'd0,
		KIND_STR = 2'd1,
		KIND_ERR = 2'd2
	} result_kind_t;

	typedef enum logic [2:0] {
		PH_VERSION = 3'd0,
		PH_SUBLEN  = 3'd1,
		PH_VENDOR  = 3'd2,
		PH_TAGFILE = 3'd3,
		PH_DATALEN = 3'd4,
		PH_TAG     = 3'd5,
		PH_VALUE   = 3'd6,
		PH_STRING  = 3'd7
	} phase_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       first_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [63:0] attr_tag;
		logic [63:0] int_value;
		logic [7:0]  string_byte;
		logic        string_last;
		logic        recognized;
	} out_item_t;

	// Result of one byte step handed to the output buffer.
	typedef struct packed {
		logic      valid;
		out_item_t item;
	} step_res_t;

endpackage

@@ rtl/riscv_attribute_section_parser_core.sv @@
// ---------------------------------------------------------------------------
// riscv_attribute_section_parser_core
// Byte-stream parser for RISC-V build-attributes sections.
// ---------------------------------------------------------------------------
// One section byte is taken per transfer and one byte can be taken every
// cycle: the whole parse step (header skipping, little-endian data length,
// ULEB128 tag/value decode, arch string pass-through, oversize check) is a
// single combinational step over the parse state registers. A byte that
// completes an integer attribute, carries an arch string byte, or first
// exceeds SECTION_MAX_BYTES gives one result, registered on its input
// transfer. Results go into a two-entry buffer (output register plus
// skid register), so input keeps flowing while a result waits; input
// stalls only while both entries are held. A byte with first_byte set
// restarts the parser before it is parsed. No result is produced after
// an oversize error until the next first mark.
// ---------------------------------------------------------------------------

module riscv_attribute_section_parser_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rasp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rasp_pkg::out_item_t out_data
);
	import rasp_pkg::*;

	logic      take;
	logic      buf_full;
	step_res_t step_res;

	// an input transfer advances the parse state by one byte
	assign in_ready = !buf_full;
	assign take     = in_valid && in_ready;

	rasp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_item (in_data),
		.res     (step_res)
	);

	// result of this byte lands in the buffer in the same transfer
	rasp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && step_res.valid),
		.push_item (step_res.item),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ rtl/rasp_parser.sv @@
// ---------------------------------------------------------------------------
// rasp_parser
// Parse state registers and the per-byte next-state and result logic.
// ---------------------------------------------------------------------------
`include "riscv_attribute_section_parser_core_defines.svh"

module rasp_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  rasp_pkg::in_item_t in_item,
	output rasp_pkg::step_res_t res
);
	import rasp_pkg::*;

	phase_t            phase_q;
	logic [1:0]        hdr_cnt_q;
	logic [31:0]       data_len_q;
	logic [CNT_W-1:0]  attr_seen_q;
	logic [CNT_W-1:0]  sec_cnt_q;
	logic [63:0]       accum_q;
	logic [6:0]        shift_q;
	logic [63:0]       tag_q;
	logic              oversize_q;

	phase_t            phase_d;
	logic [1:0]        hdr_cnt_d;
	logic [31:0]       data_len_d;
	logic [CNT_W-1:0]  attr_seen_d;
	logic [CNT_W-1:0]  sec_cnt_d;
	logic [63:0]       accum_d;
	logic [6:0]        shift_d;
	logic [63:0]       tag_d;
	logic              oversize_d;

	// ULEB128 feed of the current byte into the effective accumulator
	logic [63:0] uleb_acc;
	logic [6:0]  uleb_shift;
	logic        uleb_done;
	logic [7:0]  shift_sum;
	logic [31:0] attr_lim;
	logic        attr_end;
	logic [7:0]  b;

	always_comb begin
		// first mark: start from the reset state
		phase_d     = phase_q;
		hdr_cnt_d   = hdr_cnt_q;
		data_len_d  = data_len_q;
		attr_seen_d = attr_seen_q;
		sec_cnt_d   = sec_cnt_q;
		accum_d     = accum_q;
		shift_d     = shift_q;
		tag_d       = tag_q;
		oversize_d  = oversize_q;
		if (in_item.first_byte) begin
			phase_d     = PH_VERSION;
			hdr_cnt_d   = '0;
			data_len_d  = '0;
			attr_seen_d = '0;
			sec_cnt_d   = '0;
			accum_d     = '0;
			shift_d     = '0;
			tag_d       = '0;
			oversize_d  = 1'b0;
		end

		b = in_item.byte_value;

		uleb_acc = accum_d;
		if (shift_d < ULEB_SHIFT_MAX) begin
			uleb_acc = accum_d | (64'(b[6:0]) << shift_d[5:0]);
		end
		shift_sum  = {1'b0, shift_d} + 8'd7;
		uleb_shift = (shift_sum > 8'(ULEB_SHIFT_MAX)) ? ULEB_SHIFT_MAX : shift_sum[6:0];
		uleb_done  = !b[7];

		res       = '0;
		attr_lim  = '0;
		attr_end  = 1'b0;

		if (oversize_d) begin
			// rest of the section is dropped
		end else if (sec_cnt_d >= CNT_W'(SECTION_MAX_BYTES)) begin
			oversize_d           = 1'b1;
			res.valid            = 1'b1;
			res.item.result_kind = KIND_ERR;
		end else begin
			sec_cnt_d = sec_cnt_d + 1'b1;
			if (phase_d >= PH_TAG) begin
				attr_seen_d = attr_seen_d + 1'b1;
			end

			case (phase_d)
				PH_VERSION: begin
					phase_d   = PH_SUBLEN;
					hdr_cnt_d = '0;
				end
				PH_SUBLEN: begin
					if (hdr_cnt_d == 2'd3) begin
						hdr_cnt_d = '0;
						phase_d   = PH_VENDOR;
					end else begin
						hdr_cnt_d = hdr_cnt_d + 1'b1;
					end
				end
				PH_VENDOR: begin
					if (b == 8'd0) begin
						phase_d = PH_TAGFILE;
					end
				end
				PH_TAGFILE: begin
					phase_d    = PH_DATALEN;
					hdr_cnt_d  = '0;
					data_len_d = '0;
				end
				PH_DATALEN: begin
					data_len_d = data_len_d | (32'(b) << {hdr_cnt_d, 3'b000});
					if (hdr_cnt_d == 2'd3) begin
						hdr_cnt_d   = '0;
						attr_seen_d = '0;
						attr_end    = 1'b1;
					end else begin
						hdr_cnt_d = hdr_cnt_d + 1'b1;
					end
				end
				PH_TAG: begin
					accum_d = uleb_acc;
					shift_d = uleb_shift;
					if (uleb_done) begin
						tag_d   = uleb_acc;
						accum_d = '0;
						shift_d = '0;
						phase_d = (uleb_acc == TAG_ARCH) ? PH_STRING : PH_VALUE;
					end
				end
				PH_VALUE: begin
					accum_d = uleb_acc;
					shift_d = uleb_shift;
					if (uleb_done) begin
						res.valid            = 1'b1;
						res.item.result_kind = KIND_INT;
						res.item.attr_tag    = tag_d;
						res.item.int_value   = uleb_acc;
						res.item.recognized  = (tag_d == TAG_STACK_ALIGN) ||
							(tag_d == TAG_UNALIGNED);
						attr_end = 1'b1;
					end
				end
				PH_STRING: begin
					res.valid            = 1'b1;
					res.item.result_kind = KIND_STR;
					res.item.attr_tag    = tag_d;
					res.item.string_byte = b;
					res.item.string_last = (b == 8'd0);
					res.item.recognized  = 1'b1;
					attr_end = (b == 8'd0);
				end
				default: begin
				end
			endcase

			// end of attribute: next tag or next sub-section
			if (attr_end) begin
				attr_lim = (data_len_d < DATA_LEN_HDR) ? 32'd0 : data_len_d - DATA_LEN_HDR;
				accum_d  = '0;
				shift_d  = '0;
				if (32'(attr_seen_d) >= attr_lim) begin
					phase_d   = PH_SUBLEN;
					hdr_cnt_d = '0;
				end else begin
					phase_d = PH_TAG;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_VERSION;
			hdr_cnt_q   <= '0;
			data_len_q  <= '0;
			attr_seen_q <= '0;
			sec_cnt_q   <= '0;
			accum_q     <= '0;
			shift_q     <= '0;
			tag_q       <= '0;
			oversize_q  <= 1'b0;
		end else if (take) begin
			phase_q     <= phase_d;
			hdr_cnt_q   <= hdr_cnt_d;
			data_len_q  <= data_len_d;
			attr_seen_q <= attr_seen_d;
			sec_cnt_q   <= sec_cnt_d;
			accum_q     <= accum_d;
			shift_q     <= shift_d;
			tag_q       <= tag_d;
			oversize_q  <= oversize_d;
		end
	end

	`RASP_ASSERT_ALWAYS(a_oversize_at_max, !oversize_q || (sec_cnt_q == CNT_W'(SECTION_MAX_BYTES)), "oversize flag set below the section limit")
	`RASP_ASSERT_ALWAYS(a_shift_sat, shift_q <= ULEB_SHIFT_MAX, "ULEB shift past saturation")
	`RASP_ASSERT_NEXT(a_err_sets_flag, take && res.valid && (res.item.result_kind == KIND_ERR), oversize_q, "error result without oversize flag")

endmodule

@@ rtl/rasp_out_buf.sv @@
// ---------------------------------------------------------------------------
// rasp_out_buf
// Two-entry result buffer: output register plus skid register.
// ---------------------------------------------------------------------------
`include "riscv_attribute_section_parser_core_defines.svh"

module rasp_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rasp_pkg::out_item_t  push_item,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rasp_pkg::out_item_t  out_data
);
	import rasp_pkg::*;

	out_item_t out_q;
	out_item_t skid_q;
	logic      out_v_q;
	logic      skid_v_q;
	logic      pop;

	assign pop       = out_v_q && out_ready;
	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q) begin
				out_v_q <= push;
			end else if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= push;
				end else begin
					out_v_q <= push;
				end
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q) begin
			if (push) begin
				out_q <= push_item;
			end
		end else if (pop) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= push_item;
				end
			end else if (push) begin
				out_q <= push_item;
			end
		end else if (push) begin
			skid_q <= push_item;
		end
	end

	`RASP_ASSERT_ALWAYS(a_skid_has_head, !skid_v_q || out_v_q, "skid entry without head entry")
	`RASP_ASSERT_ALWAYS(a_no_overflow, !(push && skid_v_q), "push into full buffer")
	`RASP_ASSERT_NEXT(a_skid_moves_up, pop && skid_v_q, out_v_q, "skid entry lost on transfer")

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the attributes section parser: sections are built
// as byte streams (headers, ULEB128 tags and values, arch strings, bad
// lengths, cut-off streams, oversize sections) and sent one byte per
// transfer. A local parser model predicts each result, and the results are
// compared field by field as they leave the block.
// ---------------------------------------------------------------------------

module tb_top;
	import rasp_pkg::*;

	// Length field choices for a sub-section
	localparam int LEN_EXACT = 0;   // attribute bytes plus five
	localparam int LEN_TINY  = 1;   // below five: no attributes
	localparam int LEN_SHORT = 2;   // last attribute runs past the length
	localparam int LEN_HUGE  = 3;   // random 32-bit value

	localparam int MAX_REPORTS  = 30;
	localparam int RX_HOLD_CYC  = 300;
	localparam int RANDOM_BYTES = 100;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	riscv_attribute_section_parser_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Results predicted for accepted bytes, oldest first
	out_item_t pending_attrs[$];
	// Section under construction
	logic [7:0] sec_q[$];

	int mismatch_count = 0;
	int bytes_sent     = 0;
	bit no_idle        = 1'b0;   // burst mode: no gaps on either side
	bit rx_hold_req    = 1'b0;   // asks the receiver for one long hold-off

	// -----------------------------------------------------------------------
	// Parser model state
	// -----------------------------------------------------------------------
	phase_t      ph;
	logic [1:0]  hdr_cnt;
	logic [31:0] data_len;
	logic [31:0] attr_cnt;
	int          sect_cnt;
	logic [63:0] acc;
	int          acc_shift;
	logic [63:0] cur_tag;
	bit          sect_dropped;

	function automatic void clear_parser();
		ph           = PH_VERSION;
		hdr_cnt      = '0;
		data_len     = '0;
		attr_cnt     = '0;
		sect_cnt     = 0;
		acc          = '0;
		acc_shift    = 0;
		cur_tag      = '0;
		sect_dropped = 1'b0;
	endfunction

	// One ULEB128 byte; bits at position 64 and up fall off the end
	function automatic bit uleb_take(input logic [7:0] b);
		if (acc_shift < 64)
			acc |= 64'(b[6:0]) << acc_shift;
		acc_shift = (acc_shift + 7 > 64) ? 64 : acc_shift + 7;
		return !b[7];
	endfunction

	// Between attributes: the data length decides whether the sub-section ends
	function automatic void end_attribute();
		logic [31:0] lim;
		lim       = (data_len < DATA_LEN_HDR) ? 32'd0 : data_len - DATA_LEN_HDR;
		acc       = '0;
		acc_shift = 0;
		if (attr_cnt >= lim) begin
			ph      = PH_SUBLEN;
			hdr_cnt = '0;
		end else begin
			ph = PH_TAG;
		end
	endfunction

	// Advance the model by one byte; returns 1 with the result it gives
	function automatic bit parse_section_byte(input in_item_t it, output out_item_t res);
		logic [7:0] b;
		b   = it.byte_value;
		res = '0;
		if (it.first_byte)
			clear_parser();
		if (sect_dropped)
			return 1'b0;
		if (sect_cnt >= SECTION_MAX_BYTES) begin
			sect_dropped    = 1'b1;
			res.result_kind = KIND_ERR;
			return 1'b1;
		end
		sect_cnt++;
		if (ph >= PH_TAG && attr_cnt != 32'hffff_ffff)
			attr_cnt++;
		case (ph)
		PH_VERSION: begin
			ph      = PH_SUBLEN;
			hdr_cnt = '0;
			return 1'b0;
		end
		PH_SUBLEN: begin
			if (hdr_cnt == 2'd3) begin
				hdr_cnt = '0;
				ph      = PH_VENDOR;
			end else begin
				hdr_cnt++;
			end
			return 1'b0;
		end
		PH_VENDOR: begin
			if (b == 8'h00)
				ph = PH_TAGFILE;
			return 1'b0;
		end
		PH_TAGFILE: begin
			ph       = PH_DATALEN;
			hdr_cnt  = '0;
			data_len = '0;
			return 1'b0;
		end
		PH_DATALEN: begin
			data_len |= 32'(b) << (8 * hdr_cnt);
			if (hdr_cnt == 2'd3) begin
				hdr_cnt  = '0;
				attr_cnt = '0;
				end_attribute();
			end else begin
				hdr_cnt++;
			end
			return 1'b0;
		end
		PH_TAG: begin
			if (uleb_take(b)) begin
				cur_tag   = acc;
				acc       = '0;
				acc_shift = 0;
				if (cur_tag == TAG_ARCH)
					ph = PH_STRING;
				else
					ph = PH_VALUE;
			end
			return 1'b0;
		end
		PH_VALUE: begin
			if (!uleb_take(b))
				return 1'b0;
			res.result_kind = KIND_INT;
			res.attr_tag    = cur_tag;
			res.int_value   = acc;
			res.recognized  = (cur_tag == TAG_STACK_ALIGN || cur_tag == TAG_UNALIGNED);
			end_attribute();
			return 1'b1;
		end
		default: begin
			// arch string byte, NUL closes the attribute
			res.result_kind = KIND_STR;
			res.attr_tag    = cur_tag;
			res.string_byte = b;
			res.string_last = (b == 8'h00);
			res.recognized  = 1'b1;
			if (b == 8'h00)
				end_attribute();
			return 1'b1;
		end
		endcase
	endfunction

	// -----------------------------------------------------------------------
	// Section builders
	// -----------------------------------------------------------------------
	function automatic void new_section();
		sec_q.delete();
		sec_q.push_back(8'($urandom));   // format version
	endfunction

	// pad adds redundant continuation bytes after the value
	function automatic void put_uleb(input logic [63:0] v, input int pad);
		logic [63:0] rest;
		logic [7:0]  b;
		rest = v;
		do begin
			b    = {1'b0, rest[6:0]};
			rest = rest >> 7;
			if (rest != 0 || pad > 0)
				b[7] = 1'b1;
			sec_q.push_back(b);
		end while (rest != 0);
		for (int k = pad; k > 0; k--)
			sec_q.push_back(k > 1 ? 8'h80 : 8'h00);
	endfunction

	// n continuation bytes of random payload, then a closing byte
	function automatic void put_raw_uleb(input int n);
		repeat (n) sec_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
		sec_q.push_back(8'($urandom_range(0, 127)));
	endfunction

	function automatic void put_string(input int len);
		repeat (len) sec_q.push_back(8'($urandom_range(1, 255)));
		sec_q.push_back(8'h00);
	endfunction

	function automatic logic [63:0] other_tag();
		logic [63:0] t;
		t = 64'($urandom_range(0, 40));
		if (t == TAG_ARCH)
			t = 64'd7;
		return t;
	endfunction

	function automatic void put_attr();
		case ($urandom_range(0, 9))
		0, 1, 2: begin
			put_uleb(TAG_ARCH, ($urandom_range(0, 9) == 0) ? 2 : 0);
			put_string($urandom_range(0, 10));
		end
		3, 4: begin
			put_uleb($urandom_range(0, 1) ? TAG_STACK_ALIGN : TAG_UNALIGNED, 0);
			put_uleb(64'($urandom_range(0, 300)), 0);
		end
		5: begin
			put_uleb(other_tag(), 0);
			put_uleb({$urandom, $urandom}, 0);
		end
		6: begin
			put_raw_uleb($urandom_range(0, 11));
			put_raw_uleb($urandom_range(0, 11));
		end
		7: begin
			put_uleb(TAG_UNALIGNED, 0);
			put_uleb({$urandom, $urandom}, $urandom_range(0, 3));
		end
		8: begin
			put_uleb({$urandom, $urandom}, 0);
			put_uleb($urandom_range(0, 1) ? 64'hffff_ffff_ffff_ffff : 64'd0, 0);
		end
		default: begin
			put_uleb(other_tag(), 0);
			put_raw_uleb($urandom_range(9, 12));
		end
		endcase
	endfunction

	// Sub-section length, vendor name, file tag byte; returns where the data
	// length field sits (attributes start four bytes later)
	function automatic int open_subsection();
		int at;
		repeat (4) sec_q.push_back(8'($urandom));
		repeat ($urandom_range(0, 6)) sec_q.push_back(8'($urandom_range(1, 255)));
		sec_q.push_back(8'h00);
		sec_q.push_back(8'($urandom));
		at = sec_q.size();
		repeat (4) sec_q.push_back(8'h00);
		return at;
	endfunction

	function automatic void close_subsection(input int at, input int len_mode);
		int          cnt;
		logic [31:0] len;
		cnt = sec_q.size() - (at + 4);
		case (len_mode)
		LEN_TINY:  len = $urandom_range(0, 4);
		LEN_SHORT: len = cnt + 5 - ((cnt > 1) ? $urandom_range(1, cnt - 1) : 0);
		LEN_HUGE:  len = $urandom;
		default:   len = cnt + 5;
		endcase
		for (int k = 0; k < 4; k++)
			sec_q[at + k] = len[8*k +: 8];
	endfunction

	function automatic void put_subsection(input int n_attrs, input int len_mode);
		int at;
		at = open_subsection();
		repeat (n_attrs) put_attr();
		close_subsection(at, len_mode);
	endfunction

	// -----------------------------------------------------------------------
	// Transfers
	// -----------------------------------------------------------------------
	// Mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one byte, hold it until the transfer, then update the model
	task automatic send_byte(input logic [7:0] b, input logic first);
		in_item_t  it;
		out_item_t res;
		int        gap;
		it.byte_value = b;
		it.first_byte = first;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
		if (parse_section_byte(it, res))
			pending_attrs.push_back(res);
	endtask

	task automatic send_section(input bit mark_first);
		for (int i = 0; i < sec_q.size(); i++)
			send_byte(sec_q[i], mark_first && i == 0);
	endtask

	// Sender stays quiet until every predicted result has come out
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_attrs.size() != 0) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
	endtask

	// -----------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off on request
	// -----------------------------------------------------------------------
	initial begin : rx_side
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left   = RX_HOLD_CYC;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Every output transfer is matched against the oldest prediction
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_attrs.size() == 0) begin
				report_mismatch("unpredicted result", 64'(out_data.result_kind), 64'd0);
			end else begin
				want = pending_attrs.pop_front();
				if (out_data.result_kind !== want.result_kind)
					report_mismatch("result_kind", 64'(out_data.result_kind),
						64'(want.result_kind));
				if (out_data.attr_tag !== want.attr_tag)
					report_mismatch("attr_tag", out_data.attr_tag, want.attr_tag);
				if (out_data.int_value !== want.int_value)
					report_mismatch("int_value", out_data.int_value, want.int_value);
				if (out_data.string_byte !== want.string_byte)
					report_mismatch("string_byte", 64'(out_data.string_byte),
						64'(want.string_byte));
				if (out_data.string_last !== want.string_last)
					report_mismatch("string_last", 64'(out_data.string_last),
						64'(want.string_last));
				if (out_data.recognized !== want.recognized)
					report_mismatch("recognized", 64'(out_data.recognized),
						64'(want.recognized));
			end
		end
	end

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------
	// Parser starts as if a section began at reset, no first mark needed
	task automatic test_before_first_mark();
		int at;
		new_section();
		at = open_subsection();
		put_uleb(TAG_STACK_ALIGN, 0);
		put_uleb(64'd16, 0);
		close_subsection(at, LEN_EXACT);
		send_section(1'b0);
	endtask

	// Recognized and unknown integer tags, arch string, value extremes
	task automatic test_every_kind();
		int at;
		new_section();
		at = open_subsection();
		put_uleb(TAG_UNALIGNED, 0);
		put_uleb(64'd0, 0);
		put_uleb(TAG_ARCH, 0);
		sec_q.push_back(8'hff);
		sec_q.push_back(8'h01);
		sec_q.push_back(8'h00);
		put_uleb(TAG_STACK_ALIGN, 0);
		put_uleb(64'hffff_ffff_ffff_ffff, 0);
		put_uleb(64'hffff_ffff_ffff_ffff, 0);
		put_uleb(64'd127, 0);
		put_uleb(64'd0, 0);
		put_uleb(64'd1, 0);
		close_subsection(at, LEN_EXACT);
		send_section(1'b1);
	endtask

	// Data length below five, exactly five, and one that ends mid-attribute
	task automatic test_length_edges();
		new_section();
		put_subsection(0, LEN_TINY);
		put_subsection(0, LEN_EXACT);
		put_subsection(3, LEN_SHORT);
		put_subsection(1, LEN_EXACT);
		send_section(1'b1);
	endtask

	// ULEB128 longer than 64 bits, padded tag and value encodings
	task automatic test_long_uleb();
		int at;
		new_section();
		at = open_subsection();
		put_uleb(TAG_STACK_ALIGN, 5);
		put_uleb({$urandom, $urandom}, 4);
		put_uleb(64'd9, 0);
		put_raw_uleb(12);
		put_raw_uleb(10);
		put_raw_uleb(11);
		close_subsection(at, LEN_EXACT);
		send_section(1'b1);
	endtask

	// Stream stops mid-field; the next first mark must restart cleanly
	task automatic test_cut_short();
		int cut;
		new_section();
		put_subsection(4, LEN_EXACT);
		cut = $urandom_range(1, sec_q.size() - 2);
		repeat (cut) void'(sec_q.pop_back());
		send_section(1'b1);
		new_section();
		put_subsection(2, LEN_EXACT);
		send_section(1'b1);
	endtask

	// Three bytes over the limit: every byte up to the limit is parsed, the
	// next one gives one error and the rest are dropped
	task automatic test_oversize();
		new_section();
		while (sec_q.size() < SECTION_MAX_BYTES + 3)
			put_subsection($urandom_range(2, 8), LEN_EXACT);
		while (sec_q.size() > SECTION_MAX_BYTES + 3)
			void'(sec_q.pop_back());
		send_section(1'b1);
	endtask

	// Receiver holds off while bytes keep coming: block fills, input stalls
	task automatic test_backpressure();
		rx_hold_req = 1'b1;
		no_idle     = 1'b1;
		new_section();
		put_subsection(8, LEN_EXACT);
		send_section(1'b1);
		no_idle = 1'b0;
		wait_drain();
	endtask

	// Mostly well-formed sections with random content; some bad lengths,
	// cut-off streams and plain noise
	task automatic test_random();
		int start;
		int r;
		int cut;
		start = bytes_sent;
		while (bytes_sent < start + RANDOM_BYTES) begin
			r       = $urandom_range(0, 99);
			no_idle = ($urandom_range(0, 4) == 0);
			new_section();
			if (r < 90) begin
				repeat ($urandom_range(1, 3))
					put_subsection($urandom_range(1, 6),
						(r < 75) ? LEN_EXACT : $urandom_range(LEN_TINY, LEN_HUGE));
			end else begin
				repeat ($urandom_range(1, 40)) sec_q.push_back(8'($urandom));
			end
			if (r >= 82 && r < 90) begin
				cut = $urandom_range(1, sec_q.size() - 1);
				repeat (cut) void'(sec_q.pop_back());
			end
			send_section(1'b1);
			if ($urandom_range(0, 19) == 0)
				wait_drain();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		clear_parser();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_first_mark();
		test_every_kind();
		test_length_edges();
		test_long_uleb();
		test_cut_short();
		test_oversize();
		test_backpressure();
		test_random();

		// Let the last results leave, then stay quiet before the report
		wait_drain();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// Watchdog, several times the slowest legal run
	initial begin
		#30_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
